### hw/rtl/gia_pkg.sv
`default_nettype none
package gia_pkg;

    localparam int DEF_OPERAND_W = 16;
    localparam int RES_W         = 33;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_DVS  = 4'd5,
        OP_NORM = 4'd6,
        OP_CONJ = 4'd7,
        OP_NEG  = 4'd8,
        OP_EQ   = 4'd9
    } t_op;

    // control that travels beside each word through the pipe
    typedef struct packed {
        logic valid;
        t_op  cmd;
        logic bzero;
    } t_ctl;

endpackage
`default_nettype wire

### hw/rtl/gaussian_integer_alu_core.sv
`default_nettype none
// Channel  | Direction | tdata (low bit up)                      | tuser
// s_axis   | in        | cmd[3:0], a_real, a_imag, b_real, b_imag | -
// m_axis   | out       | res_real[32:0], res_imag[32:0]          | test_true, div_zero
//
// One word per cycle sustained while the output is not stalled; the stages are
// two front stages (products, sums), one stage per quotient bit of the
// restoring divider, and three back stages.
// Reset clears only the valid bits; the payload is left as it is.
// The whole pipe advances together; it halts while a result word waits
// in the output register and m_axis_tready is low, so nothing is dropped.
module gaussian_integer_alu_core
    import gia_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_W
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // cmd, a_real, a_imag, b_real, b_imag, zero fill
    input  wire logic [((4+4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // res_real, res_imag, zero fill
    output logic [((2*RES_W+7)/8)*8-1:0] m_axis_tdata,
    // test_true, div_zero
    output logic [1:0] m_axis_tuser
);

    localparam int W      = OPERAND_WIDTH;
    localparam int QW     = W + 1;
    localparam int OUT_DW = ((2*RES_W+7)/8)*8;
    localparam int SDW    = $bits(t_ctl) + 4*W + 2*RES_W + 3;

    logic en;

    // advance whenever the output register is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // front end
    t_ctl                    f_ctl;
    logic signed [W-1:0]     f_ar, f_ai, f_br, f_bi;
    logic signed [RES_W-1:0] f_simp_r, f_simp_i;
    logic                    f_test, f_neg_r, f_neg_i;
    logic [2*W+1:0]          f_num_r, f_num_i;
    logic [2*W:0]            f_den;

    gia_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_cmd    (t_op'(s_axis_tdata[3:0])),
        .i_ar     (s_axis_tdata[4 +: W]),
        .i_ai     (s_axis_tdata[4+W +: W]),
        .i_br     (s_axis_tdata[4+2*W +: W]),
        .i_bi     (s_axis_tdata[4+3*W +: W]),
        .o_ctl    (f_ctl),
        .o_ar     (f_ar),
        .o_ai     (f_ai),
        .o_br     (f_br),
        .o_bi     (f_bi),
        .o_simp_r (f_simp_r),
        .o_simp_i (f_simp_i),
        .o_test   (f_test),
        .o_neg_r  (f_neg_r),
        .o_neg_i  (f_neg_i),
        .o_num_r  (f_num_r),
        .o_num_i  (f_num_i),
        .o_den    (f_den)
    );

    // divider: one quotient bit per stage, most significant first
    logic [2*W+1:0] d_rem_r [QW+1];
    logic [2*W+1:0] d_rem_i [QW+1];
    logic [2*W:0]   d_den   [QW+1];
    logic [W:0]     d_q_r   [QW+1];
    logic [W:0]     d_q_i   [QW+1];

    assign d_rem_r[0] = f_num_r;
    assign d_rem_i[0] = f_num_i;
    assign d_den[0]   = f_den;
    assign d_q_r[0]   = '0;
    assign d_q_i[0]   = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        gia_div_step #(.W(W), .SHIFT(QW-1-k)) u_step (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_rem_r (d_rem_r[k]),
            .i_rem_i (d_rem_i[k]),
            .i_den   (d_den[k]),
            .i_q_r   (d_q_r[k]),
            .i_q_i   (d_q_i[k]),
            .o_rem_r (d_rem_r[k+1]),
            .o_rem_i (d_rem_i[k+1]),
            .o_den   (d_den[k+1]),
            .o_q_r   (d_q_r[k+1]),
            .o_q_i   (d_q_i[k+1])
        );
    end

    // side line: carry operands and simple results alongside the divider
    logic           r_side_vld [QW];
    logic [SDW-1:0] r_side     [QW];
    logic [SDW-1:0] n_side_in;
    t_ctl           s_ctl;
    logic signed [W-1:0]     s_ar, s_ai, s_br, s_bi;
    logic signed [RES_W-1:0] s_simp_r, s_simp_i;
    logic                    s_test, s_neg_r, s_neg_i;

    assign n_side_in = {f_ctl, f_ar, f_ai, f_br, f_bi, f_simp_r, f_simp_i,
                        f_test, f_neg_r, f_neg_i};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_side_vld[k] <= 1'b0;
        end else if (en) begin
            r_side_vld[0] <= f_ctl.valid;
            for (int k = 1; k < QW; k++) r_side_vld[k] <= r_side_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side_in;
            for (int k = 1; k < QW; k++) r_side[k] <= r_side[k-1];
        end
    end

    always_comb begin
        {s_ctl, s_ar, s_ai, s_br, s_bi, s_simp_r, s_simp_i,
         s_test, s_neg_r, s_neg_i} = r_side[QW-1];
        // take valid from the reset line, not the uncleared payload
        s_ctl.valid = r_side_vld[QW-1];
    end

    // back end and output register
    logic                    b_valid, b_test, b_dz;
    logic signed [RES_W-1:0] b_res_r, b_res_i;

    gia_back #(.W(W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (s_ctl),
        .i_ar     (s_ar),
        .i_ai     (s_ai),
        .i_br     (s_br),
        .i_bi     (s_bi),
        .i_simp_r (s_simp_r),
        .i_simp_i (s_simp_i),
        .i_test   (s_test),
        .i_neg_r  (s_neg_r),
        .i_neg_i  (s_neg_i),
        .i_q_r    (d_q_r[QW]),
        .i_q_i    (d_q_i[QW]),
        .o_valid  (b_valid),
        .o_res_r  (b_res_r),
        .o_res_i  (b_res_i),
        .o_test   (b_test),
        .o_dz     (b_dz)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = OUT_DW'({b_res_i, b_res_r});
    assign m_axis_tuser  = {b_dz, b_test};

    // a zero divisor word carries no result and no test flag
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("div_zero word with non-zero payload");

    // a true test leaves the imaginary part clear
    a_test_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> b_res_i == '0)
        else $error("test word with imaginary part set");

    // nothing leaves the pipe straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result word valid after reset");

endmodule
`default_nettype wire

### hw/rtl/gia_front.sv
`default_nettype none
module gia_front
    import gia_pkg::*;
#(
    parameter int W = DEF_OPERAND_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire t_op                     i_cmd,
    input  wire logic signed [W-1:0]     i_ar,
    input  wire logic signed [W-1:0]     i_ai,
    input  wire logic signed [W-1:0]     i_br,
    input  wire logic signed [W-1:0]     i_bi,
    output t_ctl                         o_ctl,
    output logic signed [W-1:0]          o_ar,
    output logic signed [W-1:0]          o_ai,
    output logic signed [W-1:0]          o_br,
    output logic signed [W-1:0]          o_bi,
    output logic signed [RES_W-1:0]      o_simp_r,
    output logic signed [RES_W-1:0]      o_simp_i,
    output logic                         o_test,
    output logic                         o_neg_r,
    output logic                         o_neg_i,
    output logic [2*W+1:0]               o_num_r,
    output logic [2*W+1:0]               o_num_i,
    output logic [2*W:0]                 o_den
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + 2;

    // stage 1: operands and all partial products
    t_ctl                    r1_ctl;
    logic signed [W-1:0]     r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [PW-1:0]    r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [PW-1:0]    r1_p_aar, r1_p_aai, r1_p_bbr, r1_p_bbi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl.cmd   <= i_cmd;
            r1_ctl.bzero <= (i_br == '0) && (i_bi == '0);
            r1_ar        <= i_ar;
            r1_ai        <= i_ai;
            r1_br        <= i_br;
            r1_bi        <= i_bi;
            r1_p_rr      <= i_ar * i_br;
            r1_p_ii      <= i_ai * i_bi;
            r1_p_ri      <= i_ar * i_bi;
            r1_p_ir      <= i_ai * i_br;
            r1_p_aar     <= i_ar * i_ar;
            r1_p_aai     <= i_ai * i_ai;
            r1_p_bbr     <= i_br * i_br;
            r1_p_bbi     <= i_bi * i_bi;
        end
    end

    // stage 2: sums, simple results and divider operands
    logic signed [SW-1:0]    n_mr, n_mi, n_mul_r, n_mul_i;
    logic [SW-1:0]           n_mag_r, n_mag_i;
    logic [PW-1:0]           n_nb, n_na;
    logic signed [RES_W-1:0] n_simp_r, n_simp_i;
    logic                    n_test;

    always_comb begin
        n_mr    = SW'(r1_p_rr) + SW'(r1_p_ii);
        n_mi    = SW'(r1_p_ir) - SW'(r1_p_ri);
        n_mul_r = SW'(r1_p_rr) - SW'(r1_p_ii);
        n_mul_i = SW'(r1_p_ri) + SW'(r1_p_ir);
        n_nb    = $unsigned(r1_p_bbr) + $unsigned(r1_p_bbi);
        n_na    = $unsigned(r1_p_aar) + $unsigned(r1_p_aai);
        n_mag_r = n_mr[SW-1] ? $unsigned(-n_mr) : $unsigned(n_mr);
        n_mag_i = n_mi[SW-1] ? $unsigned(-n_mi) : $unsigned(n_mi);
        n_simp_r = '0;
        n_simp_i = '0;
        n_test   = 1'b0;
        case (r1_ctl.cmd)
            OP_ADD: begin
                n_simp_r = RES_W'((W+1)'(r1_ar) + (W+1)'(r1_br));
                n_simp_i = RES_W'((W+1)'(r1_ai) + (W+1)'(r1_bi));
            end
            OP_SUB: begin
                n_simp_r = RES_W'((W+1)'(r1_ar) - (W+1)'(r1_br));
                n_simp_i = RES_W'((W+1)'(r1_ai) - (W+1)'(r1_bi));
            end
            OP_MUL: begin
                n_simp_r = RES_W'(n_mul_r);
                n_simp_i = RES_W'(n_mul_i);
            end
            OP_NORM: begin
                n_simp_r = RES_W'({1'b0, n_na});
            end
            OP_CONJ: begin
                n_simp_r = RES_W'(r1_ar);
                n_simp_i = RES_W'(-((W+1)'(r1_ai)));
            end
            OP_NEG: begin
                n_simp_r = RES_W'(-((W+1)'(r1_ar)));
                n_simp_i = RES_W'(-((W+1)'(r1_ai)));
            end
            OP_EQ: begin
                n_test = (r1_ar == r1_br) && (r1_ai == r1_bi);
            end
            default: begin
                n_test = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl.valid <= r1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.cmd   <= r1_ctl.cmd;
            o_ctl.bzero <= r1_ctl.bzero;
            o_ar        <= r1_ar;
            o_ai        <= r1_ai;
            o_br        <= r1_br;
            o_bi        <= r1_bi;
            o_simp_r    <= n_simp_r;
            o_simp_i    <= n_simp_i;
            o_test      <= n_test;
            o_neg_r     <= n_mr[SW-1];
            o_neg_i     <= n_mi[SW-1];
            // round half away: (2|m| + n) / 2n
            o_num_r     <= {n_mag_r, 1'b0} + {2'b00, n_nb};
            o_num_i     <= {n_mag_i, 1'b0} + {2'b00, n_nb};
            o_den       <= {n_nb, 1'b0};
        end
    end

endmodule
`default_nettype wire

### hw/rtl/gia_div_step.sv
`default_nettype none
module gia_div_step
    import gia_pkg::*;
#(
    parameter int W     = DEF_OPERAND_W,
    parameter int SHIFT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [2*W+1:0]   i_rem_r,
    input  wire logic [2*W+1:0]   i_rem_i,
    input  wire logic [2*W:0]     i_den,
    input  wire logic [W:0]       i_q_r,
    input  wire logic [W:0]       i_q_i,
    output logic [2*W+1:0]        o_rem_r,
    output logic [2*W+1:0]        o_rem_i,
    output logic [2*W:0]          o_den,
    output logic [W:0]            o_q_r,
    output logic [W:0]            o_q_i
);

    localparam int NW = 2 * W + 2;
    localparam int EW = NW + W + 1;

    logic [EW-1:0] n_trial, n_ext_r, n_ext_i;
    logic          n_take_r, n_take_i;

    always_comb begin
        n_trial  = EW'(i_den) << SHIFT;
        n_ext_r  = EW'(i_rem_r);
        n_ext_i  = EW'(i_rem_i);
        n_take_r = n_ext_r >= n_trial;
        n_take_i = n_ext_i >= n_trial;
    end

    // one restoring step per lane: subtract the shifted divisor where it fits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem_r <= n_take_r ? NW'(n_ext_r - n_trial) : i_rem_r;
            o_rem_i <= n_take_i ? NW'(n_ext_i - n_trial) : i_rem_i;
            o_den   <= i_den;
            o_q_r   <= i_q_r | ((W+1)'(n_take_r) << SHIFT);
            o_q_i   <= i_q_i | ((W+1)'(n_take_i) << SHIFT);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/gia_back.sv
`default_nettype none
module gia_back
    import gia_pkg::*;
#(
    parameter int W = DEF_OPERAND_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_ctl                    i_ctl,
    input  wire logic signed [W-1:0]     i_ar,
    input  wire logic signed [W-1:0]     i_ai,
    input  wire logic signed [W-1:0]     i_br,
    input  wire logic signed [W-1:0]     i_bi,
    input  wire logic signed [RES_W-1:0] i_simp_r,
    input  wire logic signed [RES_W-1:0] i_simp_i,
    input  wire logic                    i_test,
    input  wire logic                    i_neg_r,
    input  wire logic                    i_neg_i,
    input  wire logic [W:0]              i_q_r,
    input  wire logic [W:0]              i_q_i,
    output logic                         o_valid,
    output logic signed [RES_W-1:0]      o_res_r,
    output logic signed [RES_W-1:0]      o_res_i,
    output logic                         o_test,
    output logic                         o_dz
);

    localparam int QSW = W + 2;
    localparam int MW  = QSW + W;
    localparam int XW  = MW + 1;

    // stage A: signed quotient
    t_ctl                    ra_ctl;
    logic signed [W-1:0]     ra_ar, ra_ai, ra_br, ra_bi;
    logic signed [RES_W-1:0] ra_simp_r, ra_simp_i;
    logic                    ra_test;
    logic signed [QSW-1:0]   ra_qr, ra_qi;
    logic signed [QSW-1:0]   n_qr, n_qi;

    always_comb begin
        n_qr = QSW'($signed({1'b0, i_q_r}));
        n_qi = QSW'($signed({1'b0, i_q_i}));
        if (i_neg_r) n_qr = -n_qr;
        if (i_neg_i) n_qi = -n_qi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_ctl.valid <= 1'b0;
        end else if (i_en) begin
            ra_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_ctl.cmd   <= i_ctl.cmd;
            ra_ctl.bzero <= i_ctl.bzero;
            ra_ar        <= i_ar;
            ra_ai        <= i_ai;
            ra_br        <= i_br;
            ra_bi        <= i_bi;
            ra_simp_r    <= i_simp_r;
            ra_simp_i    <= i_simp_i;
            ra_test      <= i_test;
            ra_qr        <= n_qr;
            ra_qi        <= n_qi;
        end
    end

    // stage B: quotient times divisor
    t_ctl                    rb_ctl;
    logic signed [W-1:0]     rb_ar, rb_ai;
    logic signed [RES_W-1:0] rb_simp_r, rb_simp_i;
    logic                    rb_test;
    logic signed [QSW-1:0]   rb_qr, rb_qi;
    logic signed [MW-1:0]    rb_p_rr, rb_p_ii, rb_p_ri, rb_p_ir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_ctl.valid <= 1'b0;
        end else if (i_en) begin
            rb_ctl.valid <= ra_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rb_ctl.cmd   <= ra_ctl.cmd;
            rb_ctl.bzero <= ra_ctl.bzero;
            rb_ar        <= ra_ar;
            rb_ai        <= ra_ai;
            rb_simp_r    <= ra_simp_r;
            rb_simp_i    <= ra_simp_i;
            rb_test      <= ra_test;
            rb_qr        <= ra_qr;
            rb_qi        <= ra_qi;
            rb_p_rr      <= ra_qr * ra_br;
            rb_p_ii      <= ra_qi * ra_bi;
            rb_p_ri      <= ra_qr * ra_bi;
            rb_p_ir      <= ra_qi * ra_br;
        end
    end

    // stage C: select and hold the result word
    logic signed [XW-1:0]    n_pr, n_pi;
    logic signed [RES_W-1:0] n_res_r, n_res_i;
    logic                    n_test, n_dz;

    always_comb begin
        n_pr    = XW'(rb_p_rr) - XW'(rb_p_ii);
        n_pi    = XW'(rb_p_ri) + XW'(rb_p_ir);
        n_res_r = rb_simp_r;
        n_res_i = rb_simp_i;
        n_test  = rb_test;
        n_dz    = 1'b0;
        case (rb_ctl.cmd)
            OP_DIV: begin
                n_res_r = RES_W'(rb_qr);
                n_res_i = RES_W'(rb_qi);
            end
            OP_MOD: begin
                n_res_r = RES_W'(XW'(rb_ar) - n_pr);
                n_res_i = RES_W'(XW'(rb_ai) - n_pi);
            end
            OP_DVS: begin
                n_test = (n_pr == XW'(rb_ar)) && (n_pi == XW'(rb_ai));
            end
            default: begin
                n_dz = 1'b0;
            end
        endcase
        if (rb_ctl.bzero && (rb_ctl.cmd == OP_DIV || rb_ctl.cmd == OP_MOD
                             || rb_ctl.cmd == OP_DVS)) begin
            n_res_r = '0;
            n_res_i = '0;
            n_test  = 1'b0;
            n_dz    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= rb_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_r <= n_res_r;
            o_res_i <= n_res_i;
            o_test  <= n_test;
            o_dz    <= n_dz;
        end
    end

endmodule
`default_nettype wire
